FILE: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CESD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define CESD_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/cesd_pkg.sv
package cesd_pkg;

    localparam int CHAR_W = 9;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_V  = 8'h76;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F2 = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;

    // control codes produced by the simple escapes
    localparam logic [CHAR_W-1:0] CODE_BS    = 9'h05C;
    localparam logic [CHAR_W-1:0] CODE_QUOTE = 9'h022;
    localparam logic [CHAR_W-1:0] CODE_BKSP  = 9'h008;
    localparam logic [CHAR_W-1:0] CODE_FF    = 9'h00C;
    localparam logic [CHAR_W-1:0] CODE_LF    = 9'h00A;
    localparam logic [CHAR_W-1:0] CODE_TAB   = 9'h009;
    localparam logic [CHAR_W-1:0] CODE_VT    = 9'h00B;

    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;
    localparam logic [1:0] HEX_MAX_DIGITS = 2'd2;
    // value of hex letter 'A' / 'a'
    localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

    typedef enum logic [3:0] {
        MODE_PLAIN = 4'b0001,
        MODE_ESC   = 4'b0010,
        MODE_OCT   = 4'b0100,
        MODE_HEX   = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              end_out;
        logic              last;
    } res_t;

    // results produced by one input beat
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } dec_out_t;

endpackage

FILE: hw/rtl/c_escape_sequence_decoder.sv
// channel | ports                                   | beat
// input   | s_valid s_ready s_byte_in s_end_in      | one raw byte or end marker
// result  | m_valid m_ready m_char_out m_end_out m_last | one decoded character
//
// one input beat per cycle while the queue has room; zero to two results per beat
// land in a four-entry queue, one per output beat, so the input rate is set by the queue
// input is taken while the queue has room for two, independent of m_ready in that cycle
// aresetn is synchronous, active low; clears decode mode, digit run and queue
module c_escape_sequence_decoder
    import cesd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_byte_in,
    input  logic              s_end_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char_out,
    output logic              m_end_out,
    output logic              m_last
);

    dec_out_t dec;
    logic     fire;
    logic     room;

    // input handshake
    assign s_ready = room;
    assign fire    = s_valid && s_ready;

    cesd_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .byte_in (s_byte_in),
        .end_in  (s_end_in),
        .dec     (dec)
    );

    cesd_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fire),
        .dec        (dec),
        .room       (room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_char_out (m_char_out),
        .m_end_out  (m_end_out),
        .m_last     (m_last)
    );

endmodule

FILE: hw/rtl/cesd_decode.sv
`include "assert_macros.svh"

module cesd_decode
    import cesd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] byte_in,
    input  logic       end_in,
    output dec_out_t   dec
);

    mode_t             mode_reg, mode_next;
    logic [CHAR_W-1:0] val_reg, val_next;
    logic [1:0]        cnt_reg, cnt_next;

    logic              is_oct, is_dec, is_lo_hex, is_up_hex, is_hex;
    logic [3:0]        hex_d;
    logic [CHAR_W-1:0] oct_acc, hex_acc;
    logic [1:0]        cnt_inc;
    logic              pre_vld, tail_vld, tail_end, do_plain;
    logic [CHAR_W-1:0] pre_ch, tail_ch;
    res_t              pre_r, tail_r;

    // digit classes of the incoming byte
    assign is_oct    = (byte_in >= CH_ZERO) && (byte_in <= CH_SEVEN);
    assign is_dec    = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
    assign is_lo_hex = (byte_in >= CH_LOW_A) && (byte_in <= CH_LOW_F2);
    assign is_up_hex = (byte_in >= CH_UP_A) && (byte_in <= CH_UP_F);
    assign is_hex    = is_dec || is_lo_hex || is_up_hex;
    assign hex_d     = is_dec ? byte_in[3:0] : 4'(byte_in[3:0] - 4'd1 + HEX_ALPHA_BASE);

    // shift-add of the next digit, kept to 9 bits
    assign oct_acc = {val_reg[CHAR_W-4:0], byte_in[2:0]};
    assign hex_acc = {val_reg[CHAR_W-5:0], hex_d};
    assign cnt_inc = cnt_reg + 2'd1;

    // next state and up to two results
    always_comb begin
        mode_next = mode_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        pre_vld   = 1'b0;
        pre_ch    = '0;
        tail_vld  = 1'b0;
        tail_ch   = '0;
        tail_end  = 1'b0;
        do_plain  = 1'b0;

        if (end_in) begin
            unique case (mode_reg)
                MODE_ESC: begin
                    pre_vld = 1'b1;
                    pre_ch  = CODE_BS;
                end
                MODE_OCT, MODE_HEX: begin
                    pre_vld = 1'b1;
                    pre_ch  = val_reg;
                end
                default: ;
            endcase
            mode_next = MODE_PLAIN;
            val_next  = '0;
            cnt_next  = '0;
            tail_vld  = 1'b1;
            tail_end  = 1'b1;
        end else begin
            unique case (mode_reg)
                MODE_PLAIN: begin
                    do_plain = 1'b1;
                end
                MODE_ESC: begin
                    mode_next = MODE_PLAIN;
                    tail_vld  = 1'b1;
                    priority if (byte_in == BACKSLASH) begin
                        tail_ch = CODE_BS;
                    end else if (byte_in == CH_QUOTE) begin
                        tail_ch = CODE_QUOTE;
                    end else if (byte_in == CH_LOW_B) begin
                        tail_ch = CODE_BKSP;
                    end else if (byte_in == CH_LOW_F) begin
                        tail_ch = CODE_FF;
                    end else if (byte_in == CH_LOW_N) begin
                        tail_ch = CODE_LF;
                    end else if (byte_in == CH_LOW_T) begin
                        tail_ch = CODE_TAB;
                    end else if (byte_in == CH_LOW_V) begin
                        tail_ch = CODE_VT;
                    end else if (byte_in == CH_LOW_X || byte_in == CH_UP_X) begin
                        tail_vld  = 1'b0;
                        mode_next = MODE_HEX;
                        val_next  = '0;
                        cnt_next  = '0;
                    end else if (is_oct) begin
                        tail_vld  = 1'b0;
                        mode_next = MODE_OCT;
                        val_next  = CHAR_W'(byte_in[2:0]);
                        cnt_next  = 2'd1;
                    end else begin
                        // unknown escape: lone backslash, byte goes through plain path
                        tail_vld = 1'b0;
                        pre_vld  = 1'b1;
                        pre_ch   = CODE_BS;
                        do_plain = 1'b1;
                    end
                end
                MODE_OCT: begin
                    if (is_oct && (cnt_reg < OCT_MAX_DIGITS)) begin
                        val_next = oct_acc;
                        cnt_next = cnt_inc;
                        if (cnt_inc >= OCT_MAX_DIGITS) begin
                            tail_vld  = 1'b1;
                            tail_ch   = oct_acc;
                            val_next  = '0;
                            cnt_next  = '0;
                            mode_next = MODE_PLAIN;
                        end
                    end else begin
                        pre_vld  = 1'b1;
                        pre_ch   = val_reg;
                        val_next = '0;
                        cnt_next = '0;
                        do_plain = 1'b1;
                    end
                end
                MODE_HEX: begin
                    if (is_hex && (cnt_reg < HEX_MAX_DIGITS)) begin
                        val_next = hex_acc;
                        cnt_next = cnt_inc;
                        if (cnt_inc >= HEX_MAX_DIGITS) begin
                            tail_vld  = 1'b1;
                            tail_ch   = hex_acc;
                            val_next  = '0;
                            cnt_next  = '0;
                            mode_next = MODE_PLAIN;
                        end
                    end else begin
                        pre_vld  = 1'b1;
                        pre_ch   = val_reg;
                        val_next = '0;
                        cnt_next = '0;
                        do_plain = 1'b1;
                    end
                end
                default: ;
            endcase

            // ordinary byte handling
            if (do_plain) begin
                if (byte_in == BACKSLASH) begin
                    mode_next = MODE_ESC;
                end else begin
                    mode_next = MODE_PLAIN;
                    tail_vld  = 1'b1;
                    tail_ch   = CHAR_W'(byte_in);
                end
            end
        end
    end

    // pack results in order, mark the final one
    always_comb begin
        pre_r  = '{char_out: pre_ch, end_out: 1'b0, last: !tail_vld};
        tail_r = '{char_out: tail_ch, end_out: tail_end, last: 1'b1};
        dec    = '0;
        if (pre_vld && tail_vld) begin
            dec.cnt = 2'd2;
            dec.r0  = pre_r;
            dec.r1  = tail_r;
        end else if (pre_vld) begin
            dec.cnt = 2'd1;
            dec.r0  = pre_r;
        end else if (tail_vld) begin
            dec.cnt = 2'd1;
            dec.r0  = tail_r;
        end
    end

    // decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PLAIN;
            val_reg  <= '0;
            cnt_reg  <= '0;
        end else if (fire) begin
            mode_reg <= mode_next;
            val_reg  <= val_next;
            cnt_reg  <= cnt_next;
        end
    end

    `CESD_ASSERT(a_oct_count, aclk, aresetn, (mode_reg == MODE_OCT) |-> (cnt_reg == 2'd1 || cnt_reg == 2'd2), "octal run count out of range")
    `CESD_ASSERT(a_hex_count, aclk, aresetn, (mode_reg == MODE_HEX) |-> (cnt_reg < HEX_MAX_DIGITS), "hex run count out of range")
    `CESD_ASSERT(a_idle_clear, aclk, aresetn, (mode_reg == MODE_PLAIN || mode_reg == MODE_ESC) |-> (val_reg == '0 && cnt_reg == '0), "digit state not cleared outside a run")
    `CESD_ASSERT(a_end_plain, aclk, aresetn, ($past(fire) && $past(end_in)) |-> (mode_reg == MODE_PLAIN), "mode not plain after end beat")

endmodule

FILE: hw/rtl/cesd_outq.sv
`include "assert_macros.svh"

module cesd_outq
    import cesd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  dec_out_t          dec,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char_out,
    output logic              m_end_out,
    output logic              m_last
);

    localparam int DEPTH = 4;

    res_t       ent_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] push_cnt;
    logic       pop;

    // room for the two results a beat may produce
    assign room     = (count_reg <= 3'd2);
    assign m_valid  = (count_reg != 3'd0);
    assign pop      = m_valid && m_ready;
    assign push_cnt = push ? dec.cnt : 2'd0;

    assign m_char_out = ent_reg[rd_ptr_reg].char_out;
    assign m_end_out  = ent_reg[rd_ptr_reg].end_out;
    assign m_last     = ent_reg[rd_ptr_reg].last;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage, up to two entries written per beat
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            ent_reg[wr_ptr_reg] <= dec.r0;
        end
        if (push_cnt == 2'd2) begin
            ent_reg[2'(wr_ptr_reg + 2'd1)] <= dec.r1;
        end
    end

    `CESD_NEVER(a_overflow, aclk, aresetn, count_reg > 3'(DEPTH), "result queue overflow")
    `CESD_NEVER(a_push_full, aclk, aresetn, (push_cnt != 2'd0) && !room, "push without room")
    `CESD_ASSERT(a_count_track, aclk, aresetn, ($past(push_cnt) == 2'd2 && !$past(pop)) |-> (count_reg == $past(count_reg) + 3'd2), "fill count lost a pair push")

endmodule
